FILE: rtl/core/cnd_pkg.sv
package cnd_pkg;

    // stream magic, first byte first
    localparam int MagicLen = 5;
    localparam logic [7:0] MAGIC [MagicLen] = '{8'h42, 8'h46, 8'h47, 8'h4E, 8'h32};

    // chunk type codes
    localparam logic [7:0] CHUNK_RAW    = 8'h00;
    localparam logic [7:0] CHUNK_NIBBLE = 8'h01;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_TRUNC     = 3'd2;
    localparam logic [2:0] ERR_CTYPE     = 3'd3;
    localparam logic [2:0] ERR_DCOUNT    = 3'd4;
    localparam logic [2:0] ERR_NIBBLE    = 3'd5;
    localparam logic [2:0] ERR_SIZE      = 3'd6;

    // tdata width of the result channel, padded to whole bytes
    localparam int OutDataW = 176;

    typedef struct packed {
        logic [31:0] raw_chunks;
        logic [31:0] nibble_chunks;
        logic [31:0] chunk_total;
        logic [63:0] total_bytes;
        logic [2:0]  error_code;
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic        last;
    } t_result;

endpackage

FILE: rtl/core/cnd_ram.sv
module cnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/chunked_nibble_dictionary_decoder.sv
// channel   dir  tdata (low bit up)                               tuser  tlast
// s_axis    in   in_byte[7:0]                                     -      end_of_stream
// m_axis    out  out_byte, error_code, total_bytes, chunk_total,  kind   last
//                nibble_chunks, raw_chunks, zero pad to 176 bits
//
// an accepted byte waits in the input register until it is processed, then its
// results (up to three words) go into an eight-word result queue at once
// a byte is processed only when the queue has room for three words; a packed
// byte yields up to two data words and every other byte at most one
// dictionary reads are issued when the byte is accepted, from its two nibbles
// synchronous active-low reset returns the decoder to the start of a stream
module chunked_nibble_dictionary_decoder #(
    parameter int DICT_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // in_byte
    input  logic                             s_axis_tlast,   // end_of_stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_byte, error_code, total_bytes, chunk_total, nibble_chunks, raw_chunks
    output logic [cnd_pkg::OutDataW-1:0]     m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,   // kind
    output logic                             m_axis_tlast    // last
);

    import cnd_pkg::*;

    localparam int DictAw = $clog2(DICT_DEPTH);
    localparam int DcW    = $clog2(DICT_DEPTH + 1);
    localparam int QDepth = 8;
    localparam int QAw    = 3;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_SIZE, PH_COUNT, PH_CTYPE, PH_CLEN, PH_RAW,
        PH_DCOUNT, PH_DICT, PH_PLEN, PH_PACKED, PH_DONE, PH_ERROR
    } t_phase;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // decoder state
    t_phase      r_phase,         n_phase;
    logic [3:0]  r_idx,           n_idx;
    logic [63:0] r_exp_size,      n_exp_size;
    logic [31:0] r_chunks_left,   n_chunks_left;
    logic [31:0] r_chunk_len,     n_chunk_len;
    logic [15:0] r_packed_left,   n_packed_left;
    logic [31:0] r_nibbles_left,  n_nibbles_left;
    logic [DcW-1:0] r_dict_count, n_dict_count;
    logic [63:0] r_bytes_out,     n_bytes_out;
    logic [31:0] r_raw_count,     n_raw_count;
    logic [31:0] r_nib_count,     n_nib_count;
    logic [31:0] r_hdr_chunks,    n_hdr_chunks;
    logic [7:0]  r_chunk_type,    n_chunk_type;
    logic [2:0]  r_held_err,      n_held_err;

    // result queue
    t_result     r_q [QDepth];
    logic [QAw-1:0] r_wr_ptr;
    logic [QAw-1:0] r_rd_ptr;
    logic [QAw:0]   r_count;

    // per-byte work
    logic        fire;
    logic        in_acc;
    logic        pop;
    logic [2:0]  code;
    logic [1:0]  n_data;
    logic [7:0]  dat [2];
    logic        stat_en;
    t_result     stat_res;
    t_result     res [3];
    logic [1:0]  n_push;
    logic        chunk_end;
    logic [31:0] left_dec;
    logic        dict_we;
    logic [7:0]  dict_hi;
    logic [7:0]  dict_lo;
    logic        hi_ok;
    logic        lo_ok;
    logic        emit0;
    logic        emit1;

    assign fire          = r_in_valid && (r_count <= (QAw+1)'(QDepth - 3));
    assign s_axis_tready = !r_in_valid || fire;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // dictionary copies, one per nibble of a packed byte
    assign dict_we = fire && (r_phase == PH_DICT);

    cnd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_dict_hi (
        .i_clk    (i_clk),
        .i_wr_en  (dict_we),
        .i_wr_addr(DictAw'(r_idx)),
        .i_wr_data(r_in_byte),
        .i_rd_en  (in_acc),
        .i_rd_addr(DictAw'(s_axis_tdata[7:4])),
        .o_rd_data(dict_hi)
    );

    cnd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_dict_lo (
        .i_clk    (i_clk),
        .i_wr_en  (dict_we),
        .i_wr_addr(DictAw'(r_idx)),
        .i_wr_data(r_in_byte),
        .i_rd_en  (in_acc),
        .i_rd_addr(DictAw'(s_axis_tdata[3:0])),
        .o_rd_data(dict_lo)
    );

    // nibble checks for a packed byte
    assign hi_ok = {{(DcW-4){1'b0}}, r_in_byte[7:4]} < r_dict_count;
    assign lo_ok = {{(DcW-4){1'b0}}, r_in_byte[3:0]} < r_dict_count;
    assign emit0 = (r_nibbles_left != 32'd0) && hi_ok;
    assign emit1 = emit0 && (r_nibbles_left != 32'd1) && lo_ok;
    assign left_dec = r_chunks_left - 32'd1;

    // next state and results for the byte in the input register
    always_comb begin
        n_phase        = r_phase;
        n_idx          = r_idx;
        n_exp_size     = r_exp_size;
        n_chunks_left  = r_chunks_left;
        n_chunk_len    = r_chunk_len;
        n_packed_left  = r_packed_left;
        n_nibbles_left = r_nibbles_left;
        n_dict_count   = r_dict_count;
        n_bytes_out    = r_bytes_out;
        n_raw_count    = r_raw_count;
        n_nib_count    = r_nib_count;
        n_hdr_chunks   = r_hdr_chunks;
        n_chunk_type   = r_chunk_type;
        n_held_err     = r_held_err;
        code           = ERR_NONE;
        n_data         = 2'd0;
        dat[0]         = r_in_byte;
        dat[1]         = dict_lo;
        chunk_end      = 1'b0;

        unique case (r_phase)
            PH_MAGIC: begin
                if (r_in_byte != MAGIC[r_idx[2:0]]) begin
                    code = ERR_MAGIC;
                end else if (r_idx == 4'(MagicLen - 1)) begin
                    n_phase    = PH_SIZE;
                    n_idx      = 4'd0;
                    n_exp_size = 64'd0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_SIZE: begin
                n_exp_size[r_idx[2:0]*8 +: 8] = r_in_byte;
                if (r_idx == 4'd7) begin
                    n_phase      = PH_COUNT;
                    n_idx        = 4'd0;
                    n_hdr_chunks = 32'd0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_COUNT: begin
                n_hdr_chunks[r_idx[1:0]*8 +: 8] = r_in_byte;
                if (r_idx == 4'd3) begin
                    n_idx         = 4'd0;
                    n_chunks_left = n_hdr_chunks;
                    n_phase       = (n_hdr_chunks != 32'd0) ? PH_CTYPE : PH_DONE;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_CTYPE: begin
                n_chunk_type = r_in_byte;
                n_chunk_len  = 32'd0;
                n_idx        = 4'd0;
                n_phase      = PH_CLEN;
            end
            PH_CLEN: begin
                n_chunk_len[r_idx[1:0]*8 +: 8] = r_in_byte;
                if (r_idx == 4'd3) begin
                    n_idx = 4'd0;
                    if (r_chunk_type == CHUNK_RAW) begin
                        if (n_chunk_len == 32'd0) begin
                            n_raw_count = r_raw_count + 32'd1;
                            chunk_end   = 1'b1;
                        end else begin
                            n_phase = PH_RAW;
                        end
                    end else if (r_chunk_type == CHUNK_NIBBLE) begin
                        n_nibbles_left = n_chunk_len;
                        n_phase        = PH_DCOUNT;
                    end else begin
                        code = ERR_CTYPE;
                    end
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_RAW: begin
                n_data      = 2'd1;
                dat[0]      = r_in_byte;
                n_bytes_out = r_bytes_out + 64'd1;
                n_chunk_len = r_chunk_len - 32'd1;
                if (n_chunk_len == 32'd0) begin
                    n_raw_count = r_raw_count + 32'd1;
                    chunk_end   = 1'b1;
                end
            end
            PH_DCOUNT: begin
                if (r_in_byte == 8'd0 || r_in_byte > 8'(DICT_DEPTH)) begin
                    code = ERR_DCOUNT;
                end else begin
                    n_dict_count = DcW'(r_in_byte);
                    n_idx        = 4'd0;
                    n_phase      = PH_DICT;
                end
            end
            PH_DICT: begin
                if (({1'b0, r_idx} + 5'd1) >= 5'(r_dict_count)) begin
                    n_idx         = 4'd0;
                    n_packed_left = 16'd0;
                    n_phase       = PH_PLEN;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_PLEN: begin
                n_packed_left[r_idx[0]*8 +: 8] = r_in_byte;
                if (r_idx == 4'd1) begin
                    n_idx = 4'd0;
                    if (n_packed_left == 16'd0) begin
                        n_nib_count = r_nib_count + 32'd1;
                        chunk_end   = 1'b1;
                    end else begin
                        n_phase = PH_PACKED;
                    end
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_PACKED: begin
                dat[0] = dict_hi;
                dat[1] = dict_lo;
                n_data = {1'b0, emit0} + {1'b0, emit1};
                if ((r_nibbles_left != 32'd0 && !hi_ok) ||
                    (emit0 && r_nibbles_left != 32'd1 && !lo_ok)) begin
                    code = ERR_NIBBLE;
                end
                n_bytes_out    = r_bytes_out + 64'(n_data);
                n_nibbles_left = r_nibbles_left - 32'(n_data);
                if (code == ERR_NONE) begin
                    n_packed_left = r_packed_left - 16'd1;
                    if (n_packed_left == 16'd0) begin
                        n_nib_count = r_nib_count + 32'd1;
                        chunk_end   = 1'b1;
                    end
                end
            end
            PH_DONE, PH_ERROR: begin
                // trailing bytes and bytes after an error are dropped
            end
            default: begin
            end
        endcase

        // chunk wrap-up
        if (chunk_end) begin
            n_chunks_left  = left_dec;
            n_chunk_len    = 32'd0;
            n_packed_left  = 16'd0;
            n_nibbles_left = 32'd0;
            n_idx          = 4'd0;
            n_phase        = (left_dec != 32'd0) ? PH_CTYPE : PH_DONE;
        end

        // status word
        stat_res = '0;
        stat_en  = 1'b0;
        if (code != ERR_NONE) begin
            n_phase             = PH_ERROR;
            n_held_err          = code;
            stat_en             = 1'b1;
            stat_res.kind       = KIND_FAIL;
            stat_res.error_code = code;
            stat_res.last       = r_in_last;
        end else if (r_in_last) begin
            stat_en       = 1'b1;
            stat_res.last = 1'b1;
            if (n_phase == PH_ERROR) begin
                stat_res.kind       = KIND_FAIL;
                stat_res.error_code = r_held_err;
            end else if (n_phase == PH_DONE) begin
                if (n_bytes_out == r_exp_size) begin
                    stat_res.kind          = KIND_OK;
                    stat_res.total_bytes   = n_bytes_out;
                    stat_res.chunk_total   = n_hdr_chunks;
                    stat_res.nibble_chunks = n_nib_count;
                    stat_res.raw_chunks    = n_raw_count;
                end else begin
                    stat_res.kind       = KIND_FAIL;
                    stat_res.error_code = ERR_SIZE;
                end
            end else begin
                stat_res.kind       = KIND_FAIL;
                stat_res.error_code = ERR_TRUNC;
            end
        end

        // last byte of a stream: back to the start
        if (r_in_last) begin
            n_phase        = PH_MAGIC;
            n_idx          = 4'd0;
            n_exp_size     = 64'd0;
            n_chunks_left  = 32'd0;
            n_chunk_len    = 32'd0;
            n_packed_left  = 16'd0;
            n_nibbles_left = 32'd0;
            n_dict_count   = '0;
            n_bytes_out    = 64'd0;
            n_raw_count    = 32'd0;
            n_nib_count    = 32'd0;
            n_hdr_chunks   = 32'd0;
            n_chunk_type   = 8'd0;
            n_held_err     = ERR_NONE;
        end

        // data words first, then the status word
        for (int i = 0; i < 3; i++) begin
            res[i] = stat_res;
            if (i < 2 && 2'(i) < n_data) begin
                res[i]          = '0;
                res[i].kind     = KIND_DATA;
                res[i].out_byte = dat[i];
            end
        end
        n_push = n_data + {1'b0, stat_en};
    end

    // input register and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_phase        <= PH_MAGIC;
            r_idx          <= 4'd0;
            r_exp_size     <= 64'd0;
            r_chunks_left  <= 32'd0;
            r_chunk_len    <= 32'd0;
            r_packed_left  <= 16'd0;
            r_nibbles_left <= 32'd0;
            r_dict_count   <= '0;
            r_bytes_out    <= 64'd0;
            r_raw_count    <= 32'd0;
            r_nib_count    <= 32'd0;
            r_hdr_chunks   <= 32'd0;
            r_chunk_type   <= 8'd0;
            r_held_err     <= ERR_NONE;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase        <= n_phase;
                r_idx          <= n_idx;
                r_exp_size     <= n_exp_size;
                r_chunks_left  <= n_chunks_left;
                r_chunk_len    <= n_chunk_len;
                r_packed_left  <= n_packed_left;
                r_nibbles_left <= n_nibbles_left;
                r_dict_count   <= n_dict_count;
                r_bytes_out    <= n_bytes_out;
                r_raw_count    <= n_raw_count;
                r_nib_count    <= n_nib_count;
                r_hdr_chunks   <= n_hdr_chunks;
                r_chunk_type   <= n_chunk_type;
                r_held_err     <= n_held_err;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (fire) begin
                r_wr_ptr <= r_wr_ptr + QAw'(n_push);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAw'(1);
            end
            r_count <= r_count + (fire ? (QAw+1)'(n_push) : '0) - (pop ? (QAw+1)'(1) : '0);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_push) begin
                    r_q[r_wr_ptr + QAw'(i)] <= res[i];
                end
            end
        end
    end

    // output port
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {5'd0,
                            r_q[r_rd_ptr].raw_chunks,
                            r_q[r_rd_ptr].nibble_chunks,
                            r_q[r_rd_ptr].chunk_total,
                            r_q[r_rd_ptr].total_bytes,
                            r_q[r_rd_ptr].error_code,
                            r_q[r_rd_ptr].out_byte};
    assign m_axis_tuser  = r_q[r_rd_ptr].kind;
    assign m_axis_tlast  = r_q[r_rd_ptr].last;

endmodule
